// File: sv/mi_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared constants and types for the extended Euclid modular inverse unit.
// ----------------------------------------------------------------------------
package mi_pkg;

   localparam int DATA_WIDTH_DEFAULT = 64;

   // Modulus after reset, truncated to the field width where it is used.
   localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_REDUCE,
      ST_RESULT,
      ST_FINISH
   } mi_state_type;

endpackage

// File: sv/mi_divider.sv
// ----------------------------------------------------------------------------
// Modular inverse shared divider
// Restoring divider, one quotient bit per cycle, MSB first. While the
// quotient bits come out it also forms quotient times a factor, modulo
// 2^DATA_WIDTH, by shift and add.
// ----------------------------------------------------------------------------
module mi_divider
   import mi_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [DATA_WIDTH-1:0]   dividend,
   input  logic [DATA_WIDTH-2:0]   divisor,
   input  logic [DATA_WIDTH-1:0]   factor,
   output logic                    last,
   output logic [DATA_WIDTH-1:0]   remainder,
   output logic [DATA_WIDTH-1:0]   product
);

   localparam int CountWidth = $clog2(DATA_WIDTH + 1);
   localparam logic [CountWidth-1:0] StepCount = CountWidth'(DATA_WIDTH);
   localparam logic [CountWidth-1:0] OneCount  = CountWidth'(1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] prod_ff, prod_in;
   logic [DATA_WIDTH-2:0] divisor_ff, divisor_in;
   logic [DATA_WIDTH-1:0] factor_ff, factor_in;

   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH+1:0] diff;
   logic                  qbit;

   // The partial remainder stays below the divisor, so the trial value
   // needs one extra bit and the compare one more for the borrow.
   assign trial = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff  = {1'b0, trial} - {3'b000, divisor_ff};
   assign qbit  = ~diff[DATA_WIDTH+1];

   always_comb begin
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      prod_in    = prod_ff;
      divisor_in = divisor_ff;
      factor_in  = factor_ff;
      if (load) begin
         count_in   = StepCount;
         rem_in     = '0;
         quo_in     = dividend;
         prod_in    = '0;
         divisor_in = divisor;
         factor_in  = factor;
      end else if (count_ff != '0) begin
         count_in = count_ff - OneCount;
         rem_in   = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         quo_in   = {quo_ff[DATA_WIDTH-2:0], qbit};
         prod_in  = {prod_ff[DATA_WIDTH-2:0], 1'b0} + (qbit ? factor_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      prod_ff    <= prod_in;
      divisor_ff <= divisor_in;
      factor_ff  <= factor_in;
   end

   assign last      = (count_ff == OneCount);
   assign remainder = rem_ff;
   assign product   = prod_ff;

endmodule

// File: sv/modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// Modular inverse unit
// Extended Euclid modular inverse of one value against a programmable
// modulus, with the gcd returned alongside the reduced coefficient.
// ----------------------------------------------------------------------------
// Each Euclid round runs the shared bit-serial divider and the update step;
// the final reduction runs the divider once more, followed by the result
// state. About 91 rounds worst case at 64 bits.
// One value at a time: busy stays high through the result strobe, so the
// next transfer is taken in the cycle after it.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset is synchronous: modulus returns to 1000000007, the sequencer idles.
// ----------------------------------------------------------------------------
module modular_inverse_unit
   import mi_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-2:0] req_value,
   input  logic                  csr_write_enable,
   input  logic [DATA_WIDTH-2:0] csr_write_data,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-2:0] rsp_inverse,
   output logic [DATA_WIDTH-2:0] rsp_common_divisor
);

   localparam logic [DATA_WIDTH-2:0] ModulusReset = MODULUS_RESET[DATA_WIDTH-2:0];
   localparam logic [DATA_WIDTH-1:0] CoefOne      = DATA_WIDTH'(1);

   mi_state_type state_ff, state_in;

   logic [DATA_WIDTH-2:0] modulus_ff;
   logic [DATA_WIDTH-2:0] a_ff;
   logic [DATA_WIDTH-2:0] b_ff;
   logic [DATA_WIDTH-1:0] u_ff;
   logic [DATA_WIDTH-1:0] v_ff;
   logic [DATA_WIDTH-2:0] inv_ff;
   logic                  neg_ff;

   logic                  div_load;
   logic [DATA_WIDTH-1:0] div_dividend;
   logic [DATA_WIDTH-2:0] div_divisor;
   logic                  div_last;
   logic [DATA_WIDTH-1:0] div_remainder;
   logic [DATA_WIDTH-1:0] div_product;

   logic                  b_zero;
   logic                  m_zero;
   logic [DATA_WIDTH-1:0] u_mag;
   logic [DATA_WIDTH-2:0] red_rem;

   assign b_zero  = (b_ff == '0);
   assign m_zero  = (modulus_ff == '0);
   assign u_mag   = u_ff[DATA_WIDTH-1] ? (~u_ff + CoefOne) : u_ff;
   assign red_rem = div_remainder[DATA_WIDTH-2:0];

   // Both the Euclid quotient and the final reduction use the same divider.
   assign div_load     = (state_ff == ST_CHECK) && !(b_zero && m_zero);
   assign div_dividend = b_zero ? u_mag : {1'b0, a_ff};
   assign div_divisor  = b_zero ? modulus_ff : b_ff;

   mi_divider #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .factor    (v_ff),
      .last      (div_last),
      .remainder (div_remainder),
      .product   (div_product)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!b_zero) state_in = ST_DIVIDE;
            else if (m_zero)      state_in = ST_FINISH;
            else                  state_in = ST_REDUCE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_CHECK;
         ST_REDUCE: begin
            if (div_last) state_in = ST_RESULT;
         end
         ST_RESULT: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         modulus_ff <= ModulusReset;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) modulus_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            a_ff <= req_value;
            b_ff <= modulus_ff;
            u_ff <= CoefOne;
            v_ff <= '0;
         end
         ST_CHECK: begin
            neg_ff <= u_ff[DATA_WIDTH-1];
            inv_ff <= '0;
         end
         ST_UPDATE: begin
            // The new remainder is below the old divisor, so it fits the field.
            a_ff <= b_ff;
            b_ff <= red_rem;
            u_ff <= v_ff;
            v_ff <= u_ff - div_product;
         end
         ST_RESULT: begin
            // A negative coefficient maps to modulus minus its residue.
            if (neg_ff && red_rem != '0) inv_ff <= modulus_ff - red_rem;
            else if (neg_ff)             inv_ff <= '0;
            else                         inv_ff <= red_rem;
         end
         ST_DIVIDE, ST_REDUCE, ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_inverse        = inv_ff;
   assign rsp_common_divisor = a_ff;

endmodule

// File: sv/mi_checker.sv
// ----------------------------------------------------------------------------
// Modular inverse port checker
// Watches the command and result ports of the modular inverse unit.
// ----------------------------------------------------------------------------
module mi_checker
   import mi_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [DATA_WIDTH-2:0] rsp_inverse,
   input logic [DATA_WIDTH-2:0] rsp_common_divisor
);

   // A transfer in makes the unit busy on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit not busy after a transfer in");

   // Busy only rises because of a transfer in.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a transfer in");

   // A result is only shown while the unit still owns the item.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // After the result the unit is free again and the strobe is single.
   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("unit still busy after result");

   // A zero gcd only comes from a zero value against a zero modulus, and
   // then the inverse is zero as well.
   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_common_divisor == '0 |-> rsp_inverse == '0)
      else $error("nonzero inverse with zero gcd");

endmodule

bind modular_inverse_unit mi_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_mi_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_inverse        (rsp_inverse),
   .rsp_common_divisor (rsp_common_divisor)
);

// File: tb/tb_modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// Modular inverse unit testbench
// Drives values into the extended Euclid inverse unit under a series of
// modulus settings, predicts each inverse and gcd in the bench, and checks
// every result strobe in order against the prediction.
// ----------------------------------------------------------------------------
module tb_modular_inverse_unit;
   import mi_pkg::*;

   localparam int FW = DATA_WIDTH_DEFAULT - 1;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_PHASES = 5;
   localparam int VALUES_PER_PHASE = 24;
   localparam logic [FW-1:0] FIELD_MAX = {FW{1'b1}};
   localparam logic [FW-1:0] FIB_91 = 63'd4660046610375530309;
   localparam logic [FW-1:0] FIB_92 = 63'd7540113804746346429;

   typedef struct packed {
      logic [FW-1:0] value;
      logic [FW-1:0] inverse;
      logic [FW-1:0] common_divisor;
   } inverse_result_type;

   class inverse_scoreboard;
      logic [FW-1:0] modulus;
      inverse_result_type pending_results[$];
      int mismatches;
      int results_checked;
      int coprime_results;

      function new();
         modulus = MODULUS_RESET[FW-1:0];
         mismatches = 0;
         results_checked = 0;
         coprime_results = 0;
      endfunction

      function void write_modulus(logic [FW-1:0] m);
         modulus = m;
      endfunction

      // Extended Euclid with coefficients kept at one bit wider than the fields,
      // wrapping the way the hardware's two's complement registers do.
      function inverse_result_type predict_inverse(logic [FW-1:0] value);
         logic [FW:0] m, a, b, u, v, q, na, nu, mag, r, inv;
         inverse_result_type res;
         m = {1'b0, modulus};
         a = {1'b0, value};
         b = m;
         u = 1;
         v = 0;
         while (b != 0) begin
            q = a / b;
            na = a - q * b;
            nu = u - q * v;
            a = b;
            b = na;
            u = v;
            v = nu;
         end
         if (m == 0) begin
            inv = 0;
         end else if (u[FW]) begin
            mag = 0 - u;
            r = mag % m;
            inv = (r == 0) ? 0 : m - r;
         end else begin
            inv = u % m;
         end
         res.value = value;
         res.inverse = inv[FW-1:0];
         res.common_divisor = a[FW-1:0];
         return res;
      endfunction

      function void note_value(logic [FW-1:0] value);
         pending_results.push_back(predict_inverse(value));
      endfunction

      function void check_result(logic [FW-1:0] inverse, logic [FW-1:0] common_divisor);
         inverse_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with nothing pending: inverse %0d gcd %0d",
                        inverse, common_divisor);
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (want.common_divisor == 1)
            coprime_results++;
         if (want.inverse !== inverse || want.common_divisor !== common_divisor) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: value %0d: inverse exp %0d got %0d, gcd exp %0d got %0d",
                        want.value, want.inverse, inverse, want.common_divisor,
                        common_divisor);
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [FW-1:0] req_value;
   logic csr_write_enable;
   logic [FW-1:0] csr_write_data;
   logic rsp_valid;
   logic [FW-1:0] rsp_inverse;
   logic [FW-1:0] rsp_common_divisor;

   inverse_scoreboard scoreboard;
   int values_sent = 0;
   int modulus_settings = 1;
   int idle_cycles = 0;
   int burst_left = 0;
   logic [FW-1:0] phase_modulus;

   modular_inverse_unit #(.DATA_WIDTH(DATA_WIDTH_DEFAULT)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_inverse(rsp_inverse),
      .rsp_common_divisor(rsp_common_divisor)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Everything is sampled here, before the block's own updates at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            scoreboard.check_result(rsp_inverse, rsp_common_divisor);
         if (csr_write_enable)
            scoreboard.write_modulus(csr_write_data);
         if (start && !busy) begin
            scoreboard.note_value(req_value);
            values_sent++;
         end
         if (rsp_valid || (start && !busy)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("ERROR: watchdog expired with %0d results pending",
                        scoreboard.pending());
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   function automatic logic [FW-1:0] random_field();
      logic [2*32-1:0] raw;
      raw = {$urandom, $urandom};
      return raw[FW-1:0];
   endfunction

   // Mixes full-range and small values with ones that share factors with the
   // modulus, sit below it, exceed it, or sit at the top of the field.
   function automatic logic [FW-1:0] random_value(logic [FW-1:0] m);
      logic [FW-1:0] pick;
      case ($urandom_range(0, 5))
         0: pick = random_field();
         1: pick = FW'($urandom_range(0, 1000));
         2: pick = m * FW'($urandom_range(1, 4));
         3: pick = (m != 0) ? random_field() % m : random_field();
         4: pick = FIELD_MAX - FW'($urandom_range(0, 100));
         default: pick = (m >> $urandom_range(0, 8)) * FW'($urandom_range(1, 5));
      endcase
      return pick;
   endfunction

   // Called at a falling edge; returns at a falling edge after the transfer.
   task automatic send_value(input logic [FW-1:0] value);
      int gap;
      start <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic program_modulus(input logic [FW-1:0] m);
      start <= 1'b0;
      @(negedge clock);
      while (scoreboard.pending() != 0 || busy)
         @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      modulus_settings++;
   endtask

   initial begin
      scoreboard = new();
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Modulus left at its reset value: zero, values at, around and above it.
      send_value('0);
      send_value(FW'(1));
      send_value(FW'(1000000006));
      send_value(FW'(1000000007));
      send_value(FW'(2000000014));
      send_value(FW'(1000000008));
      send_value(FIELD_MAX);
      send_value(FW'({(FW/2+1){2'b01}}));

      program_modulus(FIELD_MAX);
      send_value('0);
      send_value(FW'(1));
      send_value(FIELD_MAX);
      send_value(FIELD_MAX - 1);
      send_value(FW'(91));
      send_value({1'b1, {(FW-1){1'b0}}});

      program_modulus(FW'(1));
      send_value('0);
      send_value(FIELD_MAX);
      send_value(FW'(3));

      // A zero modulus is outside the legal range but the field allows it.
      program_modulus('0);
      send_value('0);
      send_value(FW'(12345));
      send_value(FIELD_MAX);

      // Consecutive Fibonacci numbers give the longest run of Euclid rounds.
      program_modulus(FIB_92);
      send_value(FIB_91);
      send_value(FW'(1));

      program_modulus({2'b01, {(FW-2){1'b0}}});
      send_value(FW'(6));
      send_value(FW'(3));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: phase_modulus = random_field() | {1'b1, {(FW-1){1'b0}}};
            1: phase_modulus = FW'($urandom_range(2, 500));
            2: phase_modulus = FW'($urandom) | FW'(2);
            3: phase_modulus = MODULUS_RESET[FW-1:0];
            default: phase_modulus = (random_field() & ~FW'(1)) | FW'(2);
         endcase
         program_modulus(phase_modulus);
         for (int i = 0; i < VALUES_PER_PHASE; i++)
            send_value(random_value(phase_modulus));
      end

      start <= 1'b0;
      while (scoreboard.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d values across %0d modulus settings; %0d results checked.",
               values_sent, modulus_settings, scoreboard.results_checked);
      $display("%0d results had gcd one, %0d did not; %0d mismatches.",
               scoreboard.coprime_results,
               scoreboard.results_checked - scoreboard.coprime_results,
               scoreboard.mismatches);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
